FILE: hw/rtl/assert_macros.svh
// Assertion macros for the JSON string unescaper RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/jsu_pkg.sv
// Types, codes and decode functions of the JSON string unescaper.
// No dependencies; the stage, decoder and top-level RTL files import this package.
`default_nettype none

package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_ESCAPE  = 2'd1,
    MODE_HEX     = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_t;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] BACKSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_U     = 8'h75;
  localparam logic [1:0] LAST_DIGIT = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [23:0] out_bytes;
    logic [1:0]  out_count;
    logic        out_end;
    logic        out_error;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_t;

  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  count;
  } utf8_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // Simple one-byte escapes; 'u' is handled separately.
  function automatic esc_t esc_map(input logic [7:0] c);
    esc_t e;
    e.ok  = 1'b1;
    e.val = c;
    unique case (c)
      8'h22, 8'h5C, 8'h2F: e.val = c;
      8'h62: e.val = 8'h08;
      8'h66: e.val = 8'h0C;
      8'h6E: e.val = 8'h0A;
      8'h72: e.val = 8'h0D;
      8'h74: e.val = 8'h09;
      default: begin
        e.ok  = 1'b0;
        e.val = 8'h00;
      end
    endcase
    return e;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t u;
    if (cp[15:7] == 9'd0) begin
      u.bytes = {17'd0, cp[6:0]};
      u.count = 2'd1;
    end else if (cp[15:11] == 5'd0) begin
      u.bytes = {8'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      u.count = 2'd2;
    end else begin
      u.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      u.count = 2'd3;
    end
    return u;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jsu_if.sv
// Valid/ready channel interfaces for raw input bytes and decoded results.
// Depends on nothing; the top level and testbench connect through these.
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] out_bytes;
  logic [1:0]  out_count;
  logic        out_end;
  logic        out_error;
  modport source (output valid, output out_bytes, output out_count, output out_end,
                  output out_error, input ready);
  modport sink (input valid, input out_bytes, input out_count, input out_end,
                input out_error, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/jsu_in_stage.sv
// Input register of the unescaper: holds one raw byte beat until decoded.
// Depends on jsu_pkg.
`default_nettype none

module jsu_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire jsu_pkg::item_t in_item,
  input  wire logic          step,
  output logic               held,
  output jsu_pkg::item_t     item
);
  import jsu_pkg::*;

  logic valid;

  assign in_ready = !valid || step;
  assign held     = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end
endmodule

`default_nettype wire

FILE: hw/rtl/jsu_decoder.sv
// Decode state and per-byte unescape logic of the JSON string unescaper.
// Depends on jsu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module jsu_decoder (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire jsu_pkg::item_t item,
  output jsu_pkg::result_t    res
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [15:0] acc, acc_next;
  logic [1:0]  seen, seen_next;

  hex_t        hex;
  esc_t        esc;
  utf8_t       utf;
  logic [15:0] acc_shift;
  logic        err;

  assign hex       = hex_value(item.in_byte);
  assign esc       = esc_map(item.in_byte);
  assign acc_shift = {acc[11:0], hex.val};
  assign utf       = utf8_encode(acc_shift);

  always_comb begin
    unique case (mode)
      MODE_NORMAL: err = (item.in_byte < CTRL_LIMIT) ||
                         (item.in_byte == BACKSLASH && item.in_last);
      MODE_ESCAPE: err = (item.in_byte == CHAR_U) ? item.in_last : !esc.ok;
      MODE_HEX:    err = !hex.ok || (seen != LAST_DIGIT && item.in_last);
      default:     err = 1'b0;
    endcase
  end

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    seen_next = seen;
    unique case (mode)
      MODE_NORMAL: begin
        if (item.in_byte == BACKSLASH) mode_next = MODE_ESCAPE;
      end
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        if (item.in_byte == CHAR_U) begin
          mode_next = MODE_HEX;
          acc_next  = 16'd0;
          seen_next = 2'd0;
        end
      end
      MODE_HEX: begin
        if (hex.ok) begin
          acc_next = acc_shift;
          if (seen == LAST_DIGIT) begin
            mode_next = MODE_NORMAL;
            seen_next = 2'd0;
          end else begin
            seen_next = seen + 2'd1;
          end
        end
      end
      default: mode_next = mode;
    endcase
    if (err) mode_next = MODE_DISCARD;
    if (item.in_last) begin
      mode_next = MODE_NORMAL;
      acc_next  = 16'd0;
      seen_next = 2'd0;
    end
  end

  always_comb begin
    res           = '0;
    res.out_end   = item.in_last;
    res.out_error = err;
    if (!err) begin
      unique case (mode)
        MODE_NORMAL: begin
          if (item.in_byte != BACKSLASH) begin
            res.out_bytes = {16'd0, item.in_byte};
            res.out_count = 2'd1;
          end
        end
        MODE_ESCAPE: begin
          if (esc.ok) begin
            res.out_bytes = {16'd0, esc.val};
            res.out_count = 2'd1;
          end
        end
        MODE_HEX: begin
          if (seen == LAST_DIGIT) begin
            res.out_bytes = utf.bytes;
            res.out_count = utf.count;
          end
        end
        default: res.out_count = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      acc  <= 16'd0;
      seen <= 2'd0;
    end else if (step) begin
      mode <= mode_next;
      acc  <= acc_next;
      seen <= seen_next;
    end
  end

  `ASSERT_CLK(a_last_resets, step && item.in_last |=> mode == MODE_NORMAL && seen == 2'd0 && acc == 16'd0, "state not cleared after last byte")
  `ASSERT_CLK(a_hold_idle, !step |=> $stable(mode) && $stable(seen) && $stable(acc), "state moved without a beat")
  `ASSERT_CLK(a_err_discard, step && res.out_error && !item.in_last |=> mode == MODE_DISCARD, "error did not start discarding")
endmodule

`default_nettype wire

FILE: hw/rtl/jsu_out_stage.sv
// Result register of the unescaper: holds one decoded beat until taken.
// Depends on jsu_pkg.
`default_nettype none

module jsu_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             held,
  input  wire jsu_pkg::result_t res_in,
  output logic                  step,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output jsu_pkg::result_t      res
);
  import jsu_pkg::*;

  logic free;

  assign free = !out_valid || out_ready;
  assign step = held && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_in;
    end
  end
endmodule

`default_nettype wire

FILE: hw/rtl/json_string_unescape.sv
// Top level of the JSON string unescaper: input register, decoder, result register.
// Depends on jsu_pkg, jsu_if, jsu_in_stage, jsu_decoder and jsu_out_stage.
//
//   channel   direction  payload                                      beats
//   raw       in         in_byte[7:0], in_last                        one per raw byte
//   decoded   out        out_bytes[23:0], out_count[1:0], out_end,    one per raw byte
//                        out_error
//
// Each raw byte yields exactly one decoded beat, via the input and result registers.
// One beat per cycle is sustained while decoded is ready; the decode of a byte sits
// between the two registers and depends on the state left by the previous byte.
// Synchronous reset clears both stage valids and returns the decoder to normal mode.
// A stall on decoded holds the result register, then the input register, then raw.
`default_nettype none

module json_string_unescape (
  input wire logic  clk,
  input wire logic  rst,
  jsu_in_if.sink    raw,
  jsu_out_if.source decoded
);
  import jsu_pkg::*;

  item_t   in_item, item;
  result_t res_dec, res;
  logic    step, held;

  assign in_item.in_byte = raw.in_byte;
  assign in_item.in_last = raw.in_last;

  jsu_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (raw.valid),
    .in_ready (raw.ready),
    .in_item  (in_item),
    .step     (step),
    .held     (held),
    .item     (item)
  );

  jsu_decoder u_dec (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .res  (res_dec)
  );

  jsu_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .held      (held),
    .res_in    (res_dec),
    .step      (step),
    .out_valid (decoded.valid),
    .out_ready (decoded.ready),
    .res       (res)
  );

  assign decoded.out_bytes = res.out_bytes;
  assign decoded.out_count = res.out_count;
  assign decoded.out_end   = res.out_end;
  assign decoded.out_error = res.out_error;
endmodule

`default_nettype wire

FILE: dv/json_string_unescape_tb.sv
// Self-checking testbench for the JSON string unescaper: random and directed strings
// go in on the raw channel, and each decoded beat is checked against a built-in decoder.
// Depends on jsu_pkg, jsu_if and the json_string_unescape top level.
`default_nettype none

module json_string_unescape_tb;
  import jsu_pkg::*;

  class unescape_scoreboard;
    mode_t       mode;
    logic [15:0] code_point;
    logic [1:0]  digits;
    result_t     expected_beats[$];
    int          mismatches;

    function new();
      mode       = MODE_NORMAL;
      code_point = '0;
      digits     = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
      return 5'd0;
    endfunction

    function void note_raw_byte(input logic [7:0] c, input logic last);
      result_t    r;
      logic       err;
      logic [4:0] nib;
      logic [7:0] b0, b1, b2;
      r   = '0;
      err = 1'b0;
      case (mode)
        MODE_NORMAL: begin
          if (c < CTRL_LIMIT) begin
            err = 1'b1;
          end else if (c == BACKSLASH) begin
            mode = MODE_ESCAPE;
            if (last) err = 1'b1;
          end else begin
            r.out_bytes = {16'd0, c};
            r.out_count = 2'd1;
          end
        end
        MODE_ESCAPE: begin
          mode = MODE_NORMAL;
          r.out_count = 2'd1;
          if (c == "\"" || c == BACKSLASH || c == "/") r.out_bytes = {16'd0, c};
          else if (c == "b") r.out_bytes = 24'h08;
          else if (c == "f") r.out_bytes = 24'h0C;
          else if (c == "n") r.out_bytes = 24'h0A;
          else if (c == "r") r.out_bytes = 24'h0D;
          else if (c == "t") r.out_bytes = 24'h09;
          else if (c == CHAR_U) begin
            r.out_count = 2'd0;
            mode        = MODE_HEX;
            code_point  = '0;
            digits      = '0;
            if (last) err = 1'b1;
          end else begin
            r.out_count = 2'd0;
            err         = 1'b1;
          end
        end
        MODE_HEX: begin
          nib = nibble_of(c);
          if (!nib[4]) begin
            err = 1'b1;
          end else begin
            code_point = {code_point[11:0], nib[3:0]};
            if (digits == LAST_DIGIT) begin
              if (code_point < 16'h0080) begin
                r.out_bytes = {16'd0, code_point[7:0]};
                r.out_count = 2'd1;
              end else if (code_point < 16'h0800) begin
                b0 = 8'hC0 | 8'(code_point >> 6);
                b1 = 8'h80 | 8'(code_point & 16'h3F);
                r.out_bytes = {8'd0, b1, b0};
                r.out_count = 2'd2;
              end else begin
                b0 = 8'hE0 | 8'(code_point >> 12);
                b1 = 8'h80 | 8'((code_point >> 6) & 16'h3F);
                b2 = 8'h80 | 8'(code_point & 16'h3F);
                r.out_bytes = {b2, b1, b0};
                r.out_count = 2'd3;
              end
              mode   = MODE_NORMAL;
              digits = '0;
            end else begin
              digits = digits + 2'd1;
              if (last) err = 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (err) begin
        r.out_bytes = '0;
        r.out_count = '0;
        mode        = MODE_DISCARD;
      end
      if (last) begin
        mode       = MODE_NORMAL;
        code_point = '0;
        digits     = '0;
      end
      r.out_end   = last;
      r.out_error = err;
      expected_beats.push_back(r);
    endfunction

    function void check_decoded(input result_t got);
      result_t exp;
      if (expected_beats.size() == 0) begin
        $error("decoded beat with no expected beat: bytes=%h count=%0d end=%b error=%b",
               got.out_bytes, got.out_count, got.out_end, got.out_error);
        mismatches++;
        return;
      end
      exp = expected_beats.pop_front();
      if (got.out_bytes !== exp.out_bytes) begin
        $error("out_bytes: expected %h, actual %h", exp.out_bytes, got.out_bytes);
        mismatches++;
      end
      if (got.out_count !== exp.out_count) begin
        $error("out_count: expected %0d, actual %0d", exp.out_count, got.out_count);
        mismatches++;
      end
      if (got.out_end !== exp.out_end) begin
        $error("out_end: expected %b, actual %b", exp.out_end, got.out_end);
        mismatches++;
      end
      if (got.out_error !== exp.out_error) begin
        $error("out_error: expected %b, actual %b", exp.out_error, got.out_error);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  jsu_in_if  raw_ch ();
  jsu_out_if dec_ch ();

  json_string_unescape i_dut (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw_ch),
    .decoded (dec_ch)
  );

  unescape_scoreboard sb;
  int unsigned        src_idle_pct;
  int unsigned        sink_idle_pct;
  bit                 hold_req;
  int unsigned        bytes_sent;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("Regression FAIL");
    $finish;
  end

  // Sink side: checks every accepted beat and drives ready with random stalls and held stalls on request.
  initial begin : sink_proc
    int unsigned stall_left;
    stall_left    = 0;
    dec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && dec_ch.valid && dec_ch.ready) begin
        sb.check_decoded('{out_bytes: dec_ch.out_bytes, out_count: dec_ch.out_count,
                           out_end: dec_ch.out_end, out_error: dec_ch.out_error});
      end
      if (stall_left > 0) begin
        stall_left--;
        dec_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req      = 1'b0;
        stall_left    = 300;
        dec_ch.ready <= 1'b0;
      end else begin
        dec_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      raw_ch.valid <= 1'b0;
      @(posedge clk);
    end
    raw_ch.valid   <= 1'b1;
    raw_ch.in_byte <= b;
    raw_ch.in_last <= last;
    do @(posedge clk); while (!raw_ch.ready);
    sb.note_raw_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic wait_drained();
    raw_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    if ($urandom_range(1)) return "A" + 8'(n) - 8'd10;
    return "a" + 8'(n) - 8'd10;
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_escape(input logic [7:0] c);
    return c == "\"" || c == BACKSLASH || c == "/" || c == "b" || c == "f" ||
           c == "n" || c == "r" || c == "t" || c == CHAR_U;
  endfunction

  task automatic send_random_string();
    logic [7:0]  s[$];
    logic [7:0]  simple[8];
    logic [7:0]  b;
    logic [15:0] cp;
    int unsigned segs, k, n;
    simple = '{"\"", BACKSLASH, "/", "b", "f", "n", "r", "t"};
    segs   = $urandom_range(6, 1);
    for (int i = 0; i < segs; i++) begin
      k = $urandom_range(99);
      if (k < 45) begin
        b = 8'($urandom_range(8'hFF, 8'h20));
        if (b == BACKSLASH) b = 8'h5D;
        s.push_back(b);
      end else if (k < 65) begin
        s.push_back(BACKSLASH);
        s.push_back(simple[$urandom_range(7)]);
      end else if (k < 85) begin
        case ($urandom_range(2))
          0: cp = 16'($urandom_range(16'h7F));
          1: cp = 16'($urandom_range(16'h7FF, 16'h80));
          default: cp = 16'($urandom_range(16'hFFFF));
        endcase
        s.push_back(BACKSLASH);
        s.push_back(CHAR_U);
        for (int d = 3; d >= 0; d--) s.push_back(hex_char(cp[4*d +: 4]));
      end else if (k < 90) begin
        s.push_back(8'($urandom_range(31)));
      end else if (k < 94) begin
        do b = 8'($urandom_range(255)); while (is_escape(b));
        s.push_back(BACKSLASH);
        s.push_back(b);
      end else if (k < 97) begin
        s.push_back(BACKSLASH);
        s.push_back(CHAR_U);
        n = $urandom_range(3);
        for (int d = 0; d < n; d++) s.push_back(hex_char(4'($urandom_range(15))));
        do b = 8'($urandom_range(255)); while (is_hex(b));
        s.push_back(b);
      end else begin
        s.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(99) < 6) begin
      s.push_back(BACKSLASH);
      if ($urandom_range(1)) begin
        s.push_back(CHAR_U);
        n = $urandom_range(3);
        for (int d = 0; d < n; d++) s.push_back(hex_char(4'($urandom_range(15))));
      end
    end
    send_string(s);
  endtask

  initial begin : stim_proc
    int unsigned src_pct[3];
    int unsigned sink_pct[3];
    bit          pressed;
    src_pct  = '{36, 48, 0};
    sink_pct = '{48, 36, 0};
    sb             = new();
    hold_req       = 1'b0;
    bytes_sent     = 0;
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    pressed        = 1'b0;
    rst            = 1'b1;
    raw_ch.valid   <= 1'b0;
    raw_ch.in_byte <= 8'h00;
    raw_ch.in_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_string('{8'h20, BACKSLASH, "n", 8'hFF});
    send_string('{8'h00});
    send_string('{8'h1F, "a"});
    send_string('{BACKSLASH, CHAR_U, "0", "0", "7", "f"});
    send_string('{BACKSLASH, CHAR_U, "F", "f", "F", "f"});
    send_string('{BACKSLASH, "q"});
    send_string('{BACKSLASH, CHAR_U, "G"});
    send_string('{BACKSLASH});
    send_string('{BACKSLASH, CHAR_U, "1", "2"});
    send_string('{8'hFF, 8'h20});
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      src_idle_pct  = src_pct[p];
      sink_idle_pct = sink_pct[p];
      bytes_sent    = 0;
      pressed       = 1'b0;
      while (bytes_sent < 640) begin
        if (p == 0 && !pressed && bytes_sent >= 200) begin
          hold_req = 1'b1;
          pressed  = 1'b1;
        end
        if (p == 1 && !pressed && bytes_sent >= 300) begin
          wait_drained();
          repeat ($urandom_range(20, 5)) @(posedge clk);
          pressed = 1'b1;
        end
        send_random_string();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
